>>> rtl/core/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// shared types, codes and defaults for the order book matcher
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int ORDER_SLOTS_DEF = 32;
    localparam int QTY_OUT_W       = 29;

    // command codes
    localparam logic [2:0] CMD_SUBMIT = 3'd0;
    localparam logic [2:0] CMD_CANCEL = 3'd1;
    localparam logic [2:0] CMD_BID    = 3'd2;
    localparam logic [2:0] CMD_ASK    = 3'd3;
    localparam logic [2:0] CMD_DEPTH  = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_TRADE  = 3'd0;
    localparam logic [2:0] KIND_DONE   = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_BID    = 3'd3;
    localparam logic [2:0] KIND_ASK    = 3'd4;
    localparam logic [2:0] KIND_DEPTH  = 3'd5;

    typedef struct packed {
        logic        valid;
        logic        side;
        logic [15:0] price;
        logic [23:0] remaining;
        logic [31:0] id;
        logic [31:0] arrival;
    } t_slot;

    typedef struct packed {
        logic [2:0]  command;
        logic        side;
        logic        market;
        logic [15:0] price;
        logic [23:0] quantity;
        logic [31:0] order_id;
    } t_in;

    typedef struct packed {
        logic [2:0]           kind;
        logic [31:0]          resting_id;
        logic [31:0]          taker_id;
        logic [15:0]          out_price;
        logic [QTY_OUT_W-1:0] out_quantity;
        logic [31:0]          trade_seq;
        logic                 ok;
        logic                 rested;
        logic                 last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic do_trade;
        logic do_finish;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_cmd_ok;
        logic in_qty_zero;
        logic scan_done;
        logic out_free;
        logic trade_go;
        logic trade_last;
    } t_stat;

endpackage

>>> rtl/core/lobm_if.sv
// ----------------------------------------------------------------------------
// lobm_in_if / lobm_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface lobm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        side;
    logic        market;
    logic [15:0] price;
    logic [23:0] quantity;
    logic [31:0] order_id;

    modport source (output valid, command, side, market, price, quantity, order_id,
                    input ready);
    modport sink (input valid, command, side, market, price, quantity, order_id,
                  output ready);
endinterface

interface lobm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] resting_id;
    logic [31:0] taker_id;
    logic [15:0] out_price;
    logic [28:0] out_quantity;
    logic [31:0] trade_seq;
    logic        ok;
    logic        rested;
    logic        last;

    modport source (output valid, kind, resting_id, taker_id, out_price, out_quantity,
                    trade_seq, ok, rested, last, input ready);
    modport sink (input valid, kind, resting_id, taker_id, out_price, out_quantity,
                  trade_seq, ok, rested, last, output ready);
endinterface

>>> rtl/core/lobm_ram.sv
// ----------------------------------------------------------------------------
// lobm_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/core/lobm_ctrl.sv
// ----------------------------------------------------------------------------
// lobm_ctrl
// sequencer: clear pass, accept, slot scan, trade or finish
// ----------------------------------------------------------------------------
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);
    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    if (!i_stat.in_cmd_ok) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.in_qty_zero) begin
                        n_state = ST_DECIDE;
                    end else begin
                        o_ctl.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.out_free) begin
                    if (i_stat.trade_go) begin
                        o_ctl.do_trade = 1'b1;
                        if (!i_stat.trade_last) begin
                            o_ctl.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                    end else begin
                        o_ctl.do_finish = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end
endmodule

>>> rtl/core/lobm_dp.sv
// ----------------------------------------------------------------------------
// lobm_dp
// slot ram, scan evaluation, trade and finish actions, result register
// ----------------------------------------------------------------------------
module lobm_dp
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in,
    input  t_ctl  i_ctl,
    output t_stat o_stat,
    output t_res  o_res,
    output logic  o_res_valid,
    input  logic  i_res_ready
);
    localparam int IW = $clog2(ORDER_SLOTS);
    localparam logic [IW:0]   CNT_END  = (IW+1)'(ORDER_SLOTS);
    localparam logic [IW-1:0] IDX_LAST = IW'(ORDER_SLOTS - 1);

    // latched command word
    logic [2:0]  r_cmd;
    logic        r_side, r_mkt;
    logic [15:0] r_price;
    logic [31:0] r_id, r_arrival, r_seq;
    logic [23:0] r_rem;

    // scan state
    logic [IW:0]   r_cnt, r_clr_cnt;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          r_b_found, r_f_found, r_c_found;
    logic [IW-1:0] r_b_idx, r_f_idx, r_c_idx;
    logic [15:0]   r_b_price;
    logic [31:0]   r_b_age, r_b_id, r_b_arr;
    logic [23:0]   r_b_rem;
    logic [QTY_OUT_W-1:0] r_sum;

    t_res r_out;
    logic r_out_vld;

    // ram ports
    logic          we;
    logic [IW-1:0] waddr;
    t_slot         wdata, rd;
    logic [$bits(t_slot)-1:0] rdata;

    lobm_ram #(.WIDTH($bits(t_slot)), .DEPTH(ORDER_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_rdata (rdata)
    );
    assign rd = t_slot'(rdata);

    logic        clearing, issue, scan_side, out_free;
    logic        cand, better, crosses, rest;
    logic [31:0] age;
    logic [23:0] fill;
    logic [QTY_OUT_W:0] sum_ext;
    t_res        res_trade, res_fin;

    assign clearing  = (r_clr_cnt != CNT_END);
    assign issue     = (r_cnt != CNT_END);
    assign scan_side = (r_cmd == CMD_SUBMIT) ? ~r_side : (r_cmd == CMD_ASK);
    assign out_free  = !r_out_vld || i_res_ready;

    // per slot evaluation
    assign cand = rd.valid && (rd.side == scan_side);
    assign age  = r_seq - rd.arrival;
    always_comb begin
        if (!r_b_found)                better = 1'b1;
        else if (rd.price != r_b_price) better = scan_side ? (rd.price < r_b_price)
                                                           : (rd.price > r_b_price);
        else                           better = (age > r_b_age);
    end
    assign sum_ext = {1'b0, r_sum} + (QTY_OUT_W+1)'(rd.remaining);

    assign crosses = r_side ? (r_b_price >= r_price) : (r_b_price <= r_price);
    assign fill    = (r_rem < r_b_rem) ? r_rem : r_b_rem;
    assign rest    = (r_cmd == CMD_SUBMIT) && !r_mkt && (r_rem != '0);

    always_comb begin
        o_stat             = '0;
        o_stat.clr_done    = !clearing;
        o_stat.in_cmd_ok   = (i_in.command <= CMD_DEPTH);
        o_stat.in_qty_zero = (i_in.command == CMD_SUBMIT) && (i_in.quantity == '0);
        o_stat.scan_done   = r_rd_vld && (r_rd_idx == IDX_LAST);
        o_stat.out_free    = out_free;
        o_stat.trade_go    = (r_cmd == CMD_SUBMIT) && (r_rem != '0) && r_b_found
                             && (r_mkt || crosses);
        o_stat.trade_last  = (r_rem <= r_b_rem);
    end

    // result words
    always_comb begin
        res_trade              = '0;
        res_trade.kind         = KIND_TRADE;
        res_trade.resting_id   = r_b_id;
        res_trade.taker_id     = r_id;
        res_trade.out_price    = r_b_price;
        res_trade.out_quantity = QTY_OUT_W'(fill);
        res_trade.trade_seq    = r_seq;
        res_trade.ok           = 1'b1;

        res_fin      = '0;
        res_fin.last = 1'b1;
        case (r_cmd)
            CMD_SUBMIT: begin
                res_fin.kind         = KIND_DONE;
                res_fin.taker_id     = r_id;
                res_fin.out_price    = r_price;
                res_fin.out_quantity = QTY_OUT_W'(r_rem);
                res_fin.trade_seq    = r_arrival;
                res_fin.ok           = !(rest && !r_f_found);
                res_fin.rested       = rest && r_f_found;
            end
            CMD_CANCEL: begin
                res_fin.kind     = KIND_CANCEL;
                res_fin.taker_id = r_id;
                res_fin.ok       = r_c_found;
            end
            CMD_BID, CMD_ASK: begin
                res_fin.kind      = (r_cmd == CMD_BID) ? KIND_BID : KIND_ASK;
                res_fin.out_price = r_b_found ? r_b_price : '0;
                res_fin.ok        = r_b_found;
            end
            default: begin
                res_fin.kind         = KIND_DEPTH;
                res_fin.out_price    = r_price;
                res_fin.out_quantity = r_sum;
                res_fin.ok           = 1'b1;
            end
        endcase
    end

    // ram write port: clear pass, fill update, resting order, cancel
    always_comb begin
        we    = 1'b0;
        waddr = r_clr_cnt[IW-1:0];
        wdata = '0;
        if (clearing) begin
            we = 1'b1;
        end else if (i_ctl.do_trade) begin
            we              = 1'b1;
            waddr           = r_b_idx;
            wdata.valid     = (r_b_rem != fill);
            wdata.side      = ~r_side;
            wdata.price     = r_b_price;
            wdata.remaining = r_b_rem - fill;
            wdata.id        = r_b_id;
            wdata.arrival   = r_b_arr;
        end else if (i_ctl.do_finish) begin
            if (rest && r_f_found) begin
                we              = 1'b1;
                waddr           = r_f_idx;
                wdata.valid     = 1'b1;
                wdata.side      = r_side;
                wdata.price     = r_price;
                wdata.remaining = r_rem;
                wdata.id        = r_id;
                wdata.arrival   = r_arrival;
            end else if (r_cmd == CMD_CANCEL && r_c_found) begin
                we    = 1'b1;
                waddr = r_c_idx;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_cnt     <= CNT_END;
            r_rd_vld  <= 1'b0;
            r_seq     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (clearing) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_ctl.scan_start) r_cnt <= '0;
            else if (issue)       r_cnt <= r_cnt + 1'b1;
            r_rd_vld <= issue;
            if (i_ctl.load && i_in.command == CMD_SUBMIT) r_seq <= r_seq + 1'b1;
            else if (i_ctl.do_trade)                       r_seq <= r_seq + 1'b1;
            if (i_ctl.do_trade || i_ctl.do_finish) r_out_vld <= 1'b1;
            else if (i_res_ready)                  r_out_vld <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IW-1:0];
        if (i_ctl.load) begin
            r_cmd     <= i_in.command;
            r_side    <= i_in.side;
            r_mkt     <= i_in.market;
            r_price   <= i_in.price;
            r_id      <= i_in.order_id;
            r_rem     <= i_in.quantity;
            r_arrival <= r_seq;
        end
        if (i_ctl.do_trade) r_rem <= r_rem - fill;
        if (i_ctl.do_trade) r_out <= res_trade;
        else if (i_ctl.do_finish) r_out <= res_fin;

        if (i_ctl.scan_start) begin
            r_b_found <= 1'b0;
            r_f_found <= 1'b0;
            r_c_found <= 1'b0;
            r_sum     <= '0;
        end else if (r_rd_vld) begin
            if (cand && better) begin
                r_b_found <= 1'b1;
                r_b_idx   <= r_rd_idx;
                r_b_price <= rd.price;
                r_b_age   <= age;
                r_b_rem   <= rd.remaining;
                r_b_id    <= rd.id;
                r_b_arr   <= rd.arrival;
            end
            if (!rd.valid && !r_f_found) begin
                r_f_found <= 1'b1;
                r_f_idx   <= r_rd_idx;
            end
            if (rd.valid && rd.id == r_id && !r_c_found) begin
                r_c_found <= 1'b1;
                r_c_idx   <= r_rd_idx;
            end
            if (rd.valid && rd.side == r_side && rd.price == r_price) begin
                r_sum <= sum_ext[QTY_OUT_W] ? '1 : sum_ext[QTY_OUT_W-1:0];
            end
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_vld;
endmodule

>>> rtl/core/limit_order_book_matcher_unit.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// price-time priority order book with trade, cancel and query commands
// ----------------------------------------------------------------------------
//  channel    dir  handshake     word
//  i_cmd_ch   in   valid/ready   command, side, market, price, quantity, order_id
//  o_res_ch   out  valid/ready   kind, ids, price, quantity, seq, ok, rested, last
//
//  a scan reads each slot once through the single ram read port and evaluates it
//  on the registered read data; a submit scans again after each trade that leaves
//  quantity open, a zero quantity submit skips the scan, other commands scan once
//  after reset a clearing pass zeroes every slot of the ram, no word taken
//  a stalled result holds the sequencer before its next trade or finish
//  i_rst_n is synchronous, active low
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit
    import lobm_pkg::*;
#(
    parameter int ORDER_SLOTS = ORDER_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lobm_in_if.sink    i_cmd_ch,
    lobm_out_if.source o_res_ch
);
    t_in   in_word;
    t_res  res_word;
    t_ctl  ctl;
    t_stat stat;
    logic  res_valid;

    // pack the command word
    assign in_word.command  = i_cmd_ch.command;
    assign in_word.side     = i_cmd_ch.side;
    assign in_word.market   = i_cmd_ch.market;
    assign in_word.price    = i_cmd_ch.price;
    assign in_word.quantity = i_cmd_ch.quantity;
    assign in_word.order_id = i_cmd_ch.order_id;

    // sequencer
    lobm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (i_cmd_ch.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // slot storage and matching datapath
    lobm_dp #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_word),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .o_res       (res_word),
        .o_res_valid (res_valid),
        .i_res_ready (o_res_ch.ready)
    );

    // result word out
    assign o_res_ch.valid        = res_valid;
    assign o_res_ch.kind         = res_word.kind;
    assign o_res_ch.resting_id   = res_word.resting_id;
    assign o_res_ch.taker_id     = res_word.taker_id;
    assign o_res_ch.out_price    = res_word.out_price;
    assign o_res_ch.out_quantity = res_word.out_quantity;
    assign o_res_ch.trade_seq    = res_word.trade_seq;
    assign o_res_ch.ok           = res_word.ok;
    assign o_res_ch.rested       = res_word.rested;
    assign o_res_ch.last         = res_word.last;

    // only the final word of a command may still wait when a new one is taken
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ch.ready |-> !(o_res_ch.valid && !o_res_ch.last))
        else $error("command taken while results pending");

    // trades carry a nonzero fill and never close a command
    a_trade_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_ch.valid && o_res_ch.kind == KIND_TRADE) |->
        (o_res_ch.out_quantity != '0 && !o_res_ch.last))
        else $error("bad trade word");

    // one trade or finish issued at a time, only with a free result register
    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.do_trade || ctl.do_finish) |->
        (!(ctl.do_trade && ctl.do_finish) && stat.out_free))
        else $error("action without free result register");
endmodule
